// ===== hdl/canrxf_pkg.sv =====
// Package for the CAN receive ID filter FIFO: state, status and register codes,
// command and status structs between controller and datapath, and the range check.
// No dependencies.
package canrxf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_REJECT_LOW   = 3'd0;
    localparam logic [2:0] CFG_REJECT_HIGH  = 3'd1;
    localparam logic [2:0] CFG_EXCLUDE_LOW  = 3'd2;
    localparam logic [2:0] CFG_EXCLUDE_HIGH = 3'd3;
    localparam logic [2:0] CFG_LOOPBACK_ID  = 3'd4;

    // Register reset values.
    localparam logic [10:0] RST_REJECT_LOW   = 11'h100;
    localparam logic [10:0] RST_REJECT_HIGH  = 11'h1FF;
    localparam logic [10:0] RST_EXCLUDE_LOW  = 11'h100;
    localparam logic [10:0] RST_EXCLUDE_HIGH = 11'h1FF;
    localparam logic [10:0] RST_LOOPBACK_ID  = 11'h2F2;

    // Node-operation loopback and response codes in data byte 0.
    localparam logic [7:0] LOOP_BYTE_A = 8'h07;
    localparam logic [7:0] LOOP_BYTE_B = 8'h08;

    localparam int ID_W   = 11;
    localparam int DATA_W = 64;
    localparam int CNT_W  = 9;

    localparam logic MODE_RECEIVE = 1'b0;

    typedef enum logic [2:0] {
        ST_QUEUED       = 3'd0,
        ST_FILTERED     = 3'd1,
        ST_DROPPED_FULL = 3'd2,
        ST_FORWARDED    = 3'd3,
        ST_EXCLUDED     = 3'd4,
        ST_EMPTY        = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture the input word
        logic rx_commit;    // filter and enqueue the captured frame
        logic empty_done;   // report a drain on an empty queue
        logic mem_read;     // read the oldest entry of the queue
        logic drain_commit; // pop the entry just read and report it
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic empty;
    } t_dp_stat;

    // An inverted range (low above high) matches nothing.
    function automatic logic in_range(input logic [10:0] id, input logic [10:0] lo,
                                      input logic [10:0] hi);
        return (id >= lo) && (id <= hi);
    endfunction

endpackage

// ===== hdl/canrxf_ctrl.sv =====
// Controller of the CAN receive ID filter FIFO: sequences one word at a time.
// Depends on canrxf_pkg.
module canrxf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  canrxf_pkg::t_dp_stat i_stat,
    output canrxf_pkg::t_dp_cmd  o_cmd
);

    canrxf_pkg::t_state r_state;
    canrxf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= canrxf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            canrxf_pkg::S_IDLE: begin
                if (start) begin
                    n_state = canrxf_pkg::S_EXEC;
                end
            end
            canrxf_pkg::S_EXEC: begin
                if (i_stat.mode == canrxf_pkg::MODE_RECEIVE || i_stat.empty) begin
                    n_state = canrxf_pkg::S_IDLE;
                end else begin
                    n_state = canrxf_pkg::S_READ;
                end
            end
            canrxf_pkg::S_READ: begin
                n_state = canrxf_pkg::S_IDLE;
            end
            default: begin
                n_state = canrxf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            canrxf_pkg::S_IDLE: begin
                busy        = 1'b0;
                o_cmd.latch = start;
            end
            canrxf_pkg::S_EXEC: begin
                if (i_stat.mode == canrxf_pkg::MODE_RECEIVE) begin
                    o_cmd.rx_commit = 1'b1;
                end else if (i_stat.empty) begin
                    o_cmd.empty_done = 1'b1;
                end else begin
                    o_cmd.mem_read = 1'b1;
                end
            end
            canrxf_pkg::S_READ: begin
                o_cmd.drain_commit = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/canrxf_dp.sv =====
// Datapath of the CAN receive ID filter FIFO: configuration registers, filters,
// frame memory with its pointers and count, and the result registers. Depends on canrxf_pkg.
module canrxf_dp #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [10:0]          i_cfg_data,
    input  logic                 i_mode,
    input  logic                 i_rx_buffer,
    input  logic [10:0]          i_frame_id,
    input  logic [63:0]          i_frame_data,
    input  canrxf_pkg::t_dp_cmd  i_cmd,
    output canrxf_pkg::t_dp_stat o_stat,
    output logic                 o_valid,
    output logic [2:0]           o_status,
    output logic [10:0]          o_out_id,
    output logic [63:0]          o_out_data,
    output logic [8:0]           o_queued_count
);

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W = canrxf_pkg::ID_W + canrxf_pkg::DATA_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [10:0] r_reject_low, r_reject_high, r_exclude_low, r_exclude_high, r_loopback_id;

    logic        r_mode;
    logic        r_rx_buffer;
    logic [10:0] r_id;
    logic [63:0] r_data;

    logic [WORD_W-1:0] r_mem [QUEUE_DEPTH];
    logic [WORD_W-1:0] r_rd_word;

    logic [IDX_W-1:0] r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             mem_we;

    logic                r_valid, n_valid;
    canrxf_pkg::t_status r_status, n_status;
    logic [10:0]         r_out_id, n_out_id;
    logic [63:0]         r_out_data, n_out_data;
    logic [8:0]          r_qcount;
    logic [31:0]         count_ext;

    logic        loop_hit;
    logic [10:0] rd_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reject_low   <= canrxf_pkg::RST_REJECT_LOW;
            r_reject_high  <= canrxf_pkg::RST_REJECT_HIGH;
            r_exclude_low  <= canrxf_pkg::RST_EXCLUDE_LOW;
            r_exclude_high <= canrxf_pkg::RST_EXCLUDE_HIGH;
            r_loopback_id  <= canrxf_pkg::RST_LOOPBACK_ID;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                canrxf_pkg::CFG_REJECT_LOW:   r_reject_low   <= i_cfg_data;
                canrxf_pkg::CFG_REJECT_HIGH:  r_reject_high  <= i_cfg_data;
                canrxf_pkg::CFG_EXCLUDE_LOW:  r_exclude_low  <= i_cfg_data;
                canrxf_pkg::CFG_EXCLUDE_HIGH: r_exclude_high <= i_cfg_data;
                canrxf_pkg::CFG_LOOPBACK_ID:  r_loopback_id  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode      <= i_mode;
            r_rx_buffer <= i_rx_buffer;
            r_id        <= i_frame_id;
            r_data      <= i_frame_data;
        end
    end

    // Frame memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= {r_id, r_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_rd_word <= r_mem[r_rd_ptr];
        end
    end

    assign loop_hit = (r_rx_buffer == 1'b0) && (r_id == r_loopback_id) &&
                      (r_data[7:0] == canrxf_pkg::LOOP_BYTE_A ||
                       r_data[7:0] == canrxf_pkg::LOOP_BYTE_B);
    assign rd_id    = r_rd_word[WORD_W-1:canrxf_pkg::DATA_W];

    always_comb begin
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_count    = r_count;
        mem_we     = 1'b0;
        n_valid    = 1'b0;
        n_status   = canrxf_pkg::ST_EMPTY;
        n_out_id   = '0;
        n_out_data = '0;
        if (i_cmd.rx_commit) begin
            n_valid = 1'b1;
            if (loop_hit || canrxf_pkg::in_range(r_id, r_reject_low, r_reject_high)) begin
                n_status = canrxf_pkg::ST_FILTERED;
            end else if (r_count == FULL_CNT) begin
                n_status = canrxf_pkg::ST_DROPPED_FULL;
            end else begin
                n_status = canrxf_pkg::ST_QUEUED;
                mem_we   = 1'b1;
                n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
                n_count  = r_count + 1'b1;
            end
        end else if (i_cmd.empty_done) begin
            n_valid  = 1'b1;
            n_status = canrxf_pkg::ST_EMPTY;
        end else if (i_cmd.drain_commit) begin
            n_valid  = 1'b1;
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
            if (canrxf_pkg::in_range(rd_id, r_exclude_low, r_exclude_high)) begin
                n_status = canrxf_pkg::ST_EXCLUDED;
            end else begin
                n_status   = canrxf_pkg::ST_FORWARDED;
                n_out_id   = rd_id;
                n_out_data = r_rd_word[canrxf_pkg::DATA_W-1:0];
            end
        end
    end

    assign count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_status   <= n_status;
            r_out_id   <= n_out_id;
            r_out_data <= n_out_data;
            r_qcount   <= count_ext[canrxf_pkg::CNT_W-1:0];
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.empty    = (r_count == '0);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_out_id        = r_out_id;
    assign o_out_data      = r_out_data;
    assign o_queued_count  = r_qcount;

endmodule

// ===== hdl/can_rx_id_filter_fifo_unit.sv =====
// Top level of the CAN receive ID filter FIFO: joins the controller and datapath.
// Depends on canrxf_pkg, canrxf_ctrl and canrxf_dp.
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ---------------------------------------------
//   command   start, busy             i_mode, i_rx_buffer, i_frame_id, i_frame_data
//   result    o_valid (one cycle)     o_status, o_out_id, o_out_data, o_queued_count
//   config    i_cfg_we                i_cfg_idx, i_cfg_data
//
// A word is taken at a clock edge with start high and busy low. A receive word
// delivers its result after the EXEC state; a drain word that finds the queue
// empty does the same, and one that pops a frame also passes through the READ
// state for the registered read of the frame memory. Busy falls in the
// same cycle the result strobe is raised, so a new word may be taken while the
// previous result is shown. The receiver cannot stall; each result is shown for
// exactly one cycle. Synchronous active-low reset empties the queue and restores
// the register defaults; the frame memory itself is not cleared, since only
// written entries are ever read.
module can_rx_id_filter_fifo_unit #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic        i_rx_buffer,
    input  logic [10:0] i_frame_id,
    input  logic [63:0] i_frame_data,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [10:0] o_out_id,
    output logic [63:0] o_out_data,
    output logic [8:0]  o_queued_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data
);

    // Commands flow from the sequencer to the datapath; the datapath answers
    // with the captured mode and whether the queue is empty.
    canrxf_pkg::t_dp_cmd  cmd;
    canrxf_pkg::t_dp_stat stat;

    canrxf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The datapath holds the filters, the frame memory and the result registers.
    canrxf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_rx_buffer    (i_rx_buffer),
        .i_frame_id     (i_frame_id),
        .i_frame_data   (i_frame_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_data     (o_out_data),
        .o_queued_count (o_queued_count)
    );

endmodule
